// File: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types, codes and defaults shared by the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam logic [4:0] CAPACITY_RESET = 5'd16;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_BADPRIO   = 2'd3;

    typedef struct packed {
        logic               op;
        logic signed [31:0] item_value;
        logic        [7:0]  item_priority;
    } req_t;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic        [7:0]  out_priority;
        logic        [1:0]  status;
        logic        [4:0]  fill_level;
    } rsp_t;

    typedef struct packed {
        logic               enq;
        logic               deq;
        logic signed [31:0] ins_value;
        logic        [7:0]  ins_prio;
    } cell_ctl_t;

endpackage

// File: hdl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, makes room on insert and
// takes its right neighbor on remove.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  spq_pkg::cell_ctl_t ctl,
    input  logic               left_keep,
    input  logic signed [31:0] left_value,
    input  logic        [7:0]  left_prio,
    input  logic signed [31:0] right_value,
    input  logic        [7:0]  right_prio,
    output logic               keep,
    output logic signed [31:0] value,
    output logic        [7:0]  prio
);
    import spq_pkg::*;

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic        [7:0]  prio_reg;
    logic        [7:0]  prio_next;

    assign keep  = (prio_reg >= ctl.ins_prio);
    assign value = value_reg;
    assign prio  = prio_reg;

    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctl.enq && !keep)
        begin
            if (left_keep)
            begin
                value_next = ctl.ins_value;
                prio_next  = ctl.ins_prio;
            end
            else
            begin
                value_next = left_value;
                prio_next  = left_prio;
            end
        end
        else if (ctl.deq)
        begin
            value_next = right_value;
            prio_next  = right_prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_reg <= '0;
        end
        else
        begin
            prio_reg <= prio_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// File: hdl/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority queue kept sorted in a chain of cells, highest priority
// at the front, equal priorities in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one operation per item:
//   enqueue of (item_value, item_priority) or dequeue of the front entry.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns one result per request
//   with the removed entry, a status code and the fill after the step.
//   Every cell compares its priority with the incoming one in parallel, so
//   the result appears in the cycle after acceptance and one item per cycle
//   is sustained while rsp_ready does not stall the output.
//   The result sits in one output register; req_ready stays high while it
//   is empty or being taken, and drops while rsp_ready holds it stalled.
//   cfg_we/cfg_wdata write the capacity (saturated at DEPTH); the user must
//   write it only while idle, the block does not enforce this. Reset empties
//   the queue, clears the output valid flag and sets the capacity to 16.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  spq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output spq_pkg::rsp_t rsp,
    input  logic          cfg_we,
    input  logic [4:0]    cfg_wdata
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    logic [4:0]       capacity_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    cell_ctl_t          ctl;
    logic               keep_arr  [DEPTH];
    logic signed [31:0] value_arr [DEPTH];
    logic        [7:0]  prio_arr  [DEPTH];

    logic             accept;
    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] usable;
    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] fill_ext;
    logic             full;
    logic             enq_ok;
    logic             deq_ok;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign cap_ext   = CMP_W'(capacity_reg);
    assign usable    = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
    assign count_ext = CMP_W'(count_reg);
    assign full      = (count_ext >= usable);
    assign enq_ok    = (req.op == OP_ENQUEUE) && !full && (req.item_priority != 8'd0);
    assign deq_ok    = (req.op == OP_DEQUEUE) && (count_reg != '0);

    assign ctl.enq       = accept && enq_ok;
    assign ctl.deq       = accept && deq_ok;
    assign ctl.ins_value = req.item_value;
    assign ctl.ins_prio  = req.item_priority;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic               lk;
            logic signed [31:0] lv;
            logic        [7:0]  lp;
            logic signed [31:0] rv;
            logic        [7:0]  rp;

            if (i == 0)
            begin : g_first
                assign lk = 1'b1;
                assign lv = req.item_value;
                assign lp = req.item_priority;
            end
            else
            begin : g_mid_l
                assign lk = keep_arr[i-1];
                assign lv = value_arr[i-1];
                assign lp = prio_arr[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign rv = value_arr[i];
                assign rp = 8'd0;
            end
            else
            begin : g_mid_r
                assign rv = value_arr[i+1];
                assign rp = prio_arr[i+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .left_keep   (lk),
                .left_value  (lv),
                .left_prio   (lp),
                .right_value (rv),
                .right_prio  (rp),
                .keep        (keep_arr[i]),
                .value       (value_arr[i]),
                .prio        (prio_arr[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctl.enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign fill_ext = CMP_W'(count_next);

    always_comb
    begin
        rsp_next.out_value    = '0;
        rsp_next.out_priority = '0;
        rsp_next.status       = ST_OK;
        rsp_next.fill_level   = fill_ext[4:0];
        if (req.op == OP_ENQUEUE)
        begin
            if (full)
            begin
                rsp_next.status = ST_OVERFLOW;
            end
            else if (req.item_priority == 8'd0)
            begin
                rsp_next.status = ST_BADPRIO;
            end
        end
        else if (!deq_ok)
        begin
            rsp_next.status = ST_UNDERFLOW;
        end
        else
        begin
            rsp_next.out_value    = value_arr[0];
            rsp_next.out_priority = prio_arr[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAPACITY_RESET;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule
